FILE: hdl/fpcvt_pkg.sv
// Package for the floating-point format converter.
// Holds the function codes and the conversion functions; no dependencies.
`default_nettype none
package fpcvt_pkg;

    typedef enum logic [1:0] {
        FUNC_H2S  = 2'd0,
        FUNC_S2H  = 2'd1,
        FUNC_B2S  = 2'd2,
        FUNC_S2B  = 2'd3
    } func_t;

    localparam int FUNC_W = 2;
    localparam int DATA_W = 32;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  p;
        logic [9:0]  mn;
        logic [31:0] r;
        e = h[14:10];
        m = h[9:0];
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                p = 4'(i);
            end
        end
        mn = m << (4'd10 - p);
        if (e == 5'd0) begin
            if (m == 10'd0) begin
                r = {h[15], 31'd0};
            end else begin
                r = {h[15], 8'(8'd103 + 8'(p)), mn, 13'd0};
            end
        end else if (e == 5'd31) begin
            r = {h[15], 8'hff, m, 13'd0};
        end else begin
            r = {h[15], 8'(8'd112 + 8'(e)), m, 13'd0};
        end
        return r;
    endfunction

    function automatic logic [15:0] single_to_half(input logic [31:0] f);
        logic [30:0] mag;
        logic [7:0]  e;
        logic [7:0]  s;
        logic [23:0] mant;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] hlf;
        logic [23:0] msk;
        logic [15:0] base;
        logic [12:0] low;
        logic [14:0] o;
        mag  = f[30:0];
        e    = mag[30:23];
        s    = 8'd126 - e;
        mant = {1'b1, mag[22:0]};
        q    = mant >> s[4:0];
        msk  = (24'd1 << s[4:0]) - 24'd1;
        rem  = mant & msk;
        hlf  = 24'd1 << (s[4:0] - 5'd1);
        base = {1'b0, 5'(e - 8'd112), mag[22:13]};
        low  = mag[12:0];
        if (mag >= 31'((127 + 16) << 23)) begin
            o = (mag > 31'h7f800000) ? 15'h7e00 : 15'h7c00;
        end else if (mag < 31'(113 << 23)) begin
            if (e == 8'd0 || s > 8'd24) begin
                o = 15'd0;
            end else begin
                if (rem > hlf || (rem == hlf && q[0])) begin
                    q = q + 24'd1;
                end
                o = q[14:0];
            end
        end else begin
            if (low > 13'h1000 || (low == 13'h1000 && base[0])) begin
                base = base + 16'd1;
            end
            o = base[14:0];
        end
        return {f[31], o};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/fp32_fp16_bf16_converter_unit.sv
// Top level of the floating-point format converter (single, half, bfloat16).
// Depends on fpcvt_pkg for function codes and conversion functions.
//
// Usage: the input channel (s_axis_*) carries one item per handshake: tuser
// holds the function code, tdata the 32-bit source pattern (16-bit sources
// in the low bits). The result channel (m_axis_*) carries the 32-bit
// converted pattern; 16-bit results sit in the low bits with the upper zero.
// An accepted item is registered at the input, converted by combinational
// logic and moved into the output register when that register is empty or
// its item is being taken; the result is offered from there. One item is
// accepted every cycle while the receiver takes results. When the receiver
// stalls, the output register holds its item and the input register keeps
// the next one; input ready drops only when both are full. Reset empties
// both registers; no result is pending.
`default_nettype none
module fp32_fp16_bf16_converter_unit
    import fpcvt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // operand[31:0]
    input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // converted[31:0]
);

    logic        in_vld_reg;
    logic [31:0] in_data_reg;
    func_t       in_func_reg;
    logic        out_vld_reg;
    logic [31:0] out_data_reg;
    logic        adv;
    logic [31:0] result;

    assign adv           = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || adv;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb begin
        case (in_func_reg)
            FUNC_H2S: result = half_to_single(in_data_reg[15:0]);
            FUNC_S2H: result = {16'd0, single_to_half(in_data_reg)};
            FUNC_B2S: result = {in_data_reg[15:0], 16'd0};
            default:  result = {16'd0, in_data_reg[31:16]};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (adv) begin
                out_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_data_reg <= s_axis_tdata;
            in_func_reg <= func_t'(s_axis_tuser);
        end
        if (adv) begin
            out_data_reg <= result;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> in_vld_reg && out_vld_reg && !m_axis_tready)
        else $error("input stalled without a full pipeline");
    a_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && (in_func_reg == FUNC_S2H || in_func_reg == FUNC_S2B)
        |=> m_axis_tdata[31:16] == 16'd0)
        else $error("16-bit result with nonzero upper half");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the single/half/bfloat16 format converter.
// Drives random and corner-case items through the stream ports and checks
// each result against an in-bench conversion model. Depends on fpcvt_pkg.
`timescale 1ns / 100ps
module testbench
    import fpcvt_pkg::*;
;

    typedef struct packed {
        func_t       func;
        logic [31:0] operand;
    } conv_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    conv_item_t  pending_items[$];
    logic [31:0] expected_words[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          send_gap = 0;
    int          take_gap = 0;
    bit          stimulus_done = 1'b0;
    bit          in_fire = 1'b0;

    localparam int WATCHDOG_LIMIT = 2000;

    fp32_fp16_bf16_converter_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  fr;
        int          lead;
        ex = h[14:10];
        fr = h[9:0];
        if (ex == 5'd0) begin
            if (fr == 10'd0) begin
                return {h[15], 31'd0};
            end
            lead = 9;
            while (!fr[lead]) begin
                lead--;
            end
            return {h[15], 8'(lead + 103), 23'((23'(fr) << (23 - lead)))};
        end
        if (ex == 5'd31) begin
            return {h[15], 8'hff, fr, 13'd0};
        end
        return {h[15], 8'(ex + 112), fr, 13'd0};
    endfunction

    function automatic logic [15:0] narrow_to_half(input logic [31:0] f);
        logic [30:0] mag;
        int          ex;
        int          sh;
        logic [23:0] mant;
        logic [23:0] quo;
        logic [23:0] rem;
        logic [23:0] halfway;
        logic [15:0] res;
        mag = f[30:0];
        ex = int'(mag[30:23]);
        if (mag >= 31'(143 << 23)) begin
            res = (mag > 31'h7f800000) ? 16'h7e00 : 16'h7c00;
        end else if (mag < 31'(113 << 23)) begin
            sh = 126 - ex;
            if (ex == 0 || sh > 24) begin
                res = 16'd0;
            end else begin
                mant = {1'b1, mag[22:0]};
                quo = mant >> sh;
                rem = mant & ((24'd1 << sh) - 24'd1);
                halfway = 24'd1 << (sh - 1);
                if (rem > halfway || (rem == halfway && quo[0])) begin
                    quo++;
                end
                res = quo[15:0];
            end
        end else begin
            res = {1'b0, 5'(ex - 112), mag[22:13]};
            if (mag[12:0] > 13'h1000 || (mag[12:0] == 13'h1000 && res[0])) begin
                res++;
            end
        end
        return res | {f[31], 15'd0};
    endfunction

    function automatic logic [31:0] convert_value(input conv_item_t it);
        case (it.func)
            FUNC_H2S: return widen_half(it.operand[15:0]);
            FUNC_S2H: return {16'd0, narrow_to_half(it.operand)};
            FUNC_B2S: return {it.operand[15:0], 16'd0};
            default:  return {16'd0, it.operand[31:16]};
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic add_item(input func_t fn, input logic [31:0] val);
        conv_item_t it;
        it.func = fn;
        it.operand = val;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] random_operand(input func_t fn);
        logic [31:0] v;
        int          k;
        v = $urandom();
        k = $urandom_range(0, 9);
        case (k)
            0: v[30:23] = 8'hff;
            1: v[30:23] = 8'h00;
            2: v[30:23] = 8'($urandom_range(100, 115));
            3: v[30:23] = 8'($urandom_range(140, 143));
            4: v[12:0] = 13'h1000;
            5: v[14:10] = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'd31;
            6: v[30:23] = 8'($urandom_range(113, 142));
            default: ;
        endcase
        if (fn == FUNC_S2H && k == 4) begin
            v[30:23] = 8'($urandom_range(113, 142));
        end
        return v;
    endfunction

    initial begin
        int n;
        func_t fn;
        add_item(FUNC_H2S, 32'hffff_0000);
        add_item(FUNC_H2S, 32'h0000_8001);
        add_item(FUNC_H2S, 32'h0000_03ff);
        add_item(FUNC_H2S, 32'h0000_7c00);
        add_item(FUNC_H2S, 32'h1234_fd55);
        add_item(FUNC_H2S, 32'h0000_3c00);
        add_item(FUNC_S2H, 32'h7fc0_0000);
        add_item(FUNC_S2H, 32'hff80_0001);
        add_item(FUNC_S2H, 32'h4780_0000);
        add_item(FUNC_S2H, 32'hff80_0000);
        add_item(FUNC_S2H, 32'h477f_f000);
        add_item(FUNC_S2H, 32'h477f_efff);
        add_item(FUNC_S2H, 32'h3380_0000);
        add_item(FUNC_S2H, 32'h3380_0001);
        add_item(FUNC_S2H, 32'h387f_f000);
        add_item(FUNC_S2H, 32'h8000_0001);
        add_item(FUNC_S2H, 32'h3f80_3000);
        add_item(FUNC_S2H, 32'h3f80_1000);
        add_item(FUNC_B2S, 32'hffff_ffff);
        add_item(FUNC_B2S, 32'h0000_0000);
        add_item(FUNC_S2B, 32'hffff_ffff);
        add_item(FUNC_S2B, 32'h7f80_0001);
        add_item(FUNC_S2B, 32'h0000_ffff);
        for (n = 0; n < 1100; n++) begin
            fn = func_t'($urandom_range(0, 3));
            add_item(fn, random_operand(fn));
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    always @(posedge aclk) begin
        in_fire <= s_axis_tvalid && s_axis_tready;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && !in_fire) begin
                s_axis_tvalid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_items[0].operand;
                s_axis_tuser <= pending_items[0].func;
                expected_words.push_back(convert_value(pending_items[0]));
                void'(pending_items.pop_front());
                send_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
                stimulus_done <= 1'b1;
            end
            if (take_gap > 0) begin
                take_gap <= take_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    take_gap <= pick_gap();
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected item: got %h", m_axis_tdata);
                end
            end else begin
                if (m_axis_tdata !== expected_words[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch: expected %h got %h",
                                 expected_words[0], m_axis_tdata);
                    end
                end
                void'(expected_words.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (stimulus_done && expected_words.size() == 0 && !s_axis_tvalid
              || idle_cycles >= WATCHDOG_LIMIT);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
        end else begin
            repeat (10) @(posedge aclk);
            if (mismatch_count == 0 && !m_axis_tvalid) begin
                $display("TB_OK");
            end else begin
                $display("TB_ERROR");
            end
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/fpcvt_pkg.sv
hdl/fp32_fp16_bf16_converter_unit.sv
tb/sv/testbench.sv
